>>> src/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

   // Buffer geometry
   localparam int MSP_BUF_BYTES = 64;
   localparam int MSP_BYTE_W    = 8;
   localparam int MSP_NUM_BANKS = 8;
   localparam int MSP_BANK_W    = 3;
   localparam int MSP_WIN_BYTES = 5;
   localparam int MSP_WIN_W     = MSP_WIN_BYTES * MSP_BYTE_W;
   localparam int MSP_IDX_W     = 7;
   localparam int MSP_VALUE_W   = 32;
   localparam int MSP_START_W   = 9;
   localparam int MSP_WIDTH_W   = 6;
   localparam int MSP_SHIFT_W   = 6;

   // Request codes
   localparam logic MSP_REQ_READ       = 1'b0;
   localparam logic MSP_REQ_WRITE      = 1'b1;
   localparam logic MSP_ORDER_INTEL    = 1'b0;
   localparam logic MSP_ORDER_MOTOROLA = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic                     byte_order;
      logic [MSP_START_W-1:0]   start_bit;
      logic [MSP_WIDTH_W-1:0]   field_width;
      logic [MSP_VALUE_W-1:0]   write_value;
   } msp_req_type;

   typedef struct packed {
      logic [MSP_VALUE_W-1:0]   read_value;
      logic                     range_error;
   } msp_rsp_type;

   typedef struct packed {
      logic                     wr_ok;
      logic [MSP_WIN_W-1:0]     wr_window;
   } msp_win_wr_type;

endpackage

>>> src/msp_bank.sv
`timescale 1ns / 1ps

module msp_bank
   import msp_pkg::*;
#(
   parameter int DEPTH  = MSP_BUF_BYTES / MSP_NUM_BANKS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     addr,
   input  logic [MSP_BYTE_W-1:0] wr_data,
   output logic [MSP_BYTE_W-1:0] rd_data
);

   logic [MSP_BYTE_W-1:0] bytes_ff [DEPTH];

   // Clear on reset, update one byte per write beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            bytes_ff[i] <= '0;
         end
      end else if (wr_en) begin
         bytes_ff[addr] <= wr_data;
      end
   end

   // Read the byte at the window row
   assign rd_data = bytes_ff[addr];

endmodule

>>> src/msp_field.sv
`timescale 1ns / 1ps

module msp_field
   import msp_pkg::*;
#(
   parameter int BUF_BYTES = MSP_BUF_BYTES
) (
   input  msp_req_type           req,
   input  logic [MSP_WIN_W-1:0]  rd_window,
   output msp_rsp_type           rsp,
   output msp_win_wr_type        win_wr
);

   localparam int unsigned BUF_LIMIT = BUF_BYTES;

   // Reverse byte order of the window: Motorola fields become contiguous
   function automatic logic [MSP_WIN_W-1:0] swap_window(input logic [MSP_WIN_W-1:0] w);
      logic [MSP_WIN_W-1:0] s;
      for (int k = 0; k < MSP_WIN_BYTES; k++) begin
         s[k*MSP_BYTE_W +: MSP_BYTE_W] = w[(MSP_WIN_BYTES-1-k)*MSP_BYTE_W +: MSP_BYTE_W];
      end
      return s;
   endfunction

   logic [2:0]              bit_off;
   logic [5:0]              first_byte;
   logic                    motorola;
   logic                    width_ok;
   logic [6:0]              mot_sum;
   logic [MSP_SHIFT_W-1:0]  shift;
   logic [MSP_SHIFT_W-1:0]  intel_top;
   logic [2:0]              last_k;
   logic [MSP_IDX_W-1:0]    last_byte;
   logic                    fits;
   logic [MSP_VALUE_W-1:0]  mask;
   logic [MSP_WIN_W-1:0]    view;
   logic [MSP_WIN_W-1:0]    view_shr;
   logic [MSP_WIN_W-1:0]    field_mask;
   logic [MSP_WIN_W-1:0]    field_val;
   logic [MSP_WIN_W-1:0]    view_new;
   logic [MSP_VALUE_W-1:0]  extracted;

   // Decode start position and width
   always_comb begin
      bit_off    = req.start_bit[2:0];
      first_byte = req.start_bit[MSP_START_W-1:3];
      motorola   = (req.byte_order == MSP_ORDER_MOTOROLA);
      width_ok   = (req.field_width != '0) &&
                   (req.field_width <= MSP_WIDTH_W'(MSP_VALUE_W));
      // Motorola LSB position in the swapped view: 33 + offset - width
      mot_sum    = 7'd33 + {4'b0, bit_off} - {1'b0, req.field_width};
      intel_top  = {3'b0, bit_off} + req.field_width - MSP_SHIFT_W'(1);
      shift      = motorola ? mot_sum[MSP_SHIFT_W-1:0] : {3'b0, bit_off};
      last_k     = motorola ? (3'(MSP_WIN_BYTES - 1) - shift[5:3]) : intel_top[5:3];
      last_byte  = {1'b0, first_byte} + {4'b0, last_k};
      fits       = width_ok && (32'(last_byte) < BUF_LIMIT);
   end

   // Field mask of 0 to 32 ones
   always_comb begin
      if (req.field_width >= MSP_WIDTH_W'(MSP_VALUE_W)) begin
         mask = '1;
      end else begin
         mask = ~({MSP_VALUE_W{1'b1}} << req.field_width[4:0]);
      end
   end

   // Extract and insert with one shared shift amount
   always_comb begin
      view       = motorola ? swap_window(rd_window) : rd_window;
      view_shr   = view >> shift;
      extracted  = view_shr[MSP_VALUE_W-1:0] & mask;
      field_mask = {8'b0, mask} << shift;
      field_val  = {8'b0, req.write_value & mask} << shift;
      view_new   = (view & ~field_mask) | field_val;
   end

   // Drive result and write-back window
   always_comb begin
      rsp.range_error  = !fits;
      rsp.read_value   = (fits && req.req_type == MSP_REQ_READ) ? extracted : '0;
      win_wr.wr_ok     = fits && (req.req_type == MSP_REQ_WRITE);
      win_wr.wr_window = motorola ? swap_window(view_new) : view_new;
   end

endmodule

>>> src/message_signal_packer_core.sv
`timescale 1ns / 1ps
// Throughput: one request beat per cycle unless the result register is full
// and rsp_ready is low; each request reads a five-byte window from eight byte
// banks, shifts it once and writes it back as it moves to the result register.
// Reset: synchronous, active high; clears the whole message buffer to zero at
// once and drops any beat in flight.

module message_signal_packer_core
   import msp_pkg::*;
#(
   parameter int BUF_BYTES = MSP_BUF_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic                    req_byte_order,
   input  logic [MSP_START_W-1:0]  req_start_bit,
   input  logic [MSP_WIDTH_W-1:0]  req_field_width,
   input  logic [MSP_VALUE_W-1:0]  req_write_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [MSP_VALUE_W-1:0]  rsp_read_value,
   output logic                    rsp_range_error
);

   localparam int          DEPTH     = (BUF_BYTES + MSP_NUM_BANKS - 1) / MSP_NUM_BANKS;
   localparam int          ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned BUF_LIMIT = BUF_BYTES;

   msp_req_type     in_ff, in_in;
   logic            in_valid_ff, in_valid_in;
   msp_rsp_type     out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   logic            advance;
   msp_win_wr_type  win_wr;

   logic [MSP_WIN_W-1:0]   rd_window;
   logic [MSP_BYTE_W-1:0]  bank_rd   [MSP_NUM_BANKS];
   logic [MSP_BYTE_W-1:0]  bank_raw  [MSP_NUM_BANKS];
   logic [MSP_BYTE_W-1:0]  wr_byte   [MSP_NUM_BANKS];
   logic [MSP_NUM_BANKS-1:0] bank_we;

   // Handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_comb begin
      in_in.req_type    = req_type;
      in_in.byte_order  = req_byte_order;
      in_in.start_bit   = req_start_bit;
      in_in.field_width = req_field_width;
      in_in.write_value = req_write_value;
      in_valid_in       = (req_valid && req_ready) || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= in_in;
      end
   end

   // Spread write-back window into per-slot bytes
   always_comb begin
      for (int k = 0; k < MSP_NUM_BANKS; k++) begin
         if (k < MSP_WIN_BYTES) begin
            wr_byte[k] = win_wr.wr_window[k*MSP_BYTE_W +: MSP_BYTE_W];
         end else begin
            wr_byte[k] = '0;
         end
      end
   end

   // Byte banks: bank j holds bytes whose index is j modulo eight
   for (genvar j = 0; j < MSP_NUM_BANKS; j++) begin : g_bank
      logic [MSP_BANK_W-1:0] slot;
      logic [MSP_IDX_W-1:0]  byte_idx;
      logic                  in_use;

      assign slot     = MSP_BANK_W'(j) - in_ff.start_bit[5:3];
      assign byte_idx = {1'b0, in_ff.start_bit[MSP_START_W-1:3]} + {4'b0, slot};
      assign in_use   = (slot < MSP_BANK_W'(MSP_WIN_BYTES)) &&
                        (32'(byte_idx) < BUF_LIMIT);
      assign bank_we[j] = advance && win_wr.wr_ok && in_use;
      assign bank_rd[j] = in_use ? bank_raw[j] : '0;

      msp_bank #(
         .DEPTH  (DEPTH),
         .ADDR_W (ADDR_W)
      ) u_bank (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (bank_we[j]),
         .addr    (ADDR_W'(byte_idx[MSP_IDX_W-1:3])),
         .wr_data (wr_byte[slot]),
         .rd_data (bank_raw[j])
      );
   end

   // Gather the five-byte window starting at the first byte
   always_comb begin
      for (int k = 0; k < MSP_WIN_BYTES; k++) begin
         rd_window[k*MSP_BYTE_W +: MSP_BYTE_W] =
            bank_rd[in_ff.start_bit[5:3] + MSP_BANK_W'(k)];
      end
   end

   msp_field #(
      .BUF_BYTES (BUF_BYTES)
   ) u_field (
      .req       (in_ff),
      .rd_window (rd_window),
      .rsp       (out_in),
      .win_wr    (win_wr)
   );

   // Result register
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_value  = out_ff.read_value;
   assign rsp_range_error = out_ff.range_error;

   // Checks
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_read_value == '0)
      else $error("range error beat carries nonzero value");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stalled while pipeline can move");

   a_write_gated: assert property (@(posedge clock) disable iff (reset)
      (|bank_we) |-> advance && in_ff.req_type == MSP_REQ_WRITE && !out_in.range_error)
      else $error("buffer written outside a good write");

   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed beat produced no result");

endmodule
